// File: rtl/core/fcps_pkg.sv
// shared constants, types and the quarter-wave sine table builder
// for the field-oriented control core; no dependencies
package fcps_pkg;

    // sine table geometry
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_ENTRIES    = (1 << SINE_TABLE_BITS) + 1;
    localparam int SINE_IDX_W      = SINE_TABLE_BITS + 1;

    // fixed-point constants
    localparam logic signed [17:0] INV_SQRT3_Q16     = 18'sd37837;
    localparam logic signed [17:0] TWO_INV_SQRT3_Q16 = 18'sd75674;

    // wide working width for the modulation arithmetic
    localparam int MOD_W = 52;

    // sextant codes
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;
    localparam logic [2:0] SECTOR_6 = 3'd6;

    typedef logic [14:0] sine_rom_t [SINE_ENTRIES];

    // quarter-wave sine table, integer taylor series in q30, built at elaboration
    // the eight series terms divide by (2n)(2n+1) for n = 1..8
    function automatic sine_rom_t sine_rom_build();
        sine_rom_t rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned e;
        for (int k = 0; k < SINE_ENTRIES; k++)
        begin
            x = (longint'(k) * 64'd1686629713) >> SINE_TABLE_BITS;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            term = ((term * x2) >> 30) / 64'd6;
            sum = sum - term;
            term = ((term * x2) >> 30) / 64'd20;
            sum = sum + term;
            term = ((term * x2) >> 30) / 64'd42;
            sum = sum - term;
            term = ((term * x2) >> 30) / 64'd72;
            sum = sum + term;
            term = ((term * x2) >> 30) / 64'd110;
            sum = sum - term;
            term = ((term * x2) >> 30) / 64'd156;
            sum = sum + term;
            term = ((term * x2) >> 30) / 64'd210;
            sum = sum - term;
            term = ((term * x2) >> 30) / 64'd272;
            sum = sum + term;
            e = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
            rom[k] = (e > 64'd32767) ? 15'd32767 : e[14:0];
        end
        return rom;
    endfunction

endpackage

// File: rtl/core/foc_clarke_park_svm_core.sv
// top level: clarke, park, inverse park and six-sector svpwm pipeline
// depends on fcps_pkg and fcps_sincos
//
//  channel | handshake           | payload
//  in      | in_valid / in_stall | rotor_angle, phase_*_current, *_voltage, bus_inverse
//  out     | out_valid/out_stall | direct/quadrature_current, duty_*, sector, duties_valid
//
// eight register stages; one request per cycle while the output is not stalled
// the stages are the table read, sign, eight products, sums, bus scaling,
// on-time products, sextant/duty sums and the output saturation register
// rst_n clears only the stage valid bits
// a stall on the output with a result waiting freezes the whole pipeline
module foc_clarke_park_svm_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        rotor_angle,
    input  logic signed [15:0] phase_a_current,
    input  logic signed [15:0] phase_b_current,
    input  logic signed [15:0] phase_c_current,
    input  logic signed [15:0] direct_voltage,
    input  logic signed [15:0] quadrature_voltage,
    input  logic [15:0]        bus_inverse,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] direct_current,
    output logic signed [15:0] quadrature_current,
    output logic [15:0]        duty_a,
    output logic [15:0]        duty_b,
    output logic [15:0]        duty_c,
    output logic [2:0]         sector,
    output logic               duties_valid
);
    import fcps_pkg::*;

    localparam int STAGES = 8;
    localparam logic signed [MOD_W-1:0] ONE_Q32 = MOD_W'(64'sd1 << 32);
    localparam logic signed [MOD_W-1:0] TWO_Q32 = MOD_W'(64'sd1 << 33);

    // duty rounding and clamp
    function automatic logic [15:0] duty_sat(input logic signed [MOD_W-1:0] d2);
        logic signed [MOD_W-1:0] q;
        q = (d2 + MOD_W'(64'sd1 << 16)) >>> 17;
        if (q < 0)
            return 16'd0;
        else if (q > MOD_W'(65535))
            return 16'hFFFF;
        else
            return q[15:0];
    endfunction

    function automatic logic duty_bad(input logic signed [MOD_W-1:0] d2);
        return (d2 < 0) || (d2 > TWO_Q32);
    endfunction

    logic               en;
    logic [STAGES-1:0]  valid_reg;
    logic [STAGES-1:0]  valid_next;

    // stage 1
    logic signed [15:0] ia_s1_reg, vd_s1_reg, vq_s1_reg;
    logic [15:0]        inv_s1_reg;
    logic signed [34:0] bprod_s1_reg;
    // stage 2
    logic signed [15:0] ia_s2_reg, vd_s2_reg, vq_s2_reg;
    logic [15:0]        inv_s2_reg;
    logic signed [17:0] ibeta_s2_reg;
    logic signed [15:0] sin_s2, cos_s2;
    // stage 3
    logic signed [31:0] p_ia_c_reg, p_ia_s_reg;
    logic signed [33:0] p_ib_s_reg, p_ib_c_reg;
    logic signed [31:0] p_vd_c_reg, p_vq_s_reg, p_vd_s_reg, p_vq_c_reg;
    logic [15:0]        inv_s3_reg;
    // stage 4
    logic signed [15:0] id_s4_reg, iq_s4_reg;
    logic signed [32:0] va_s4_reg, vb_s4_reg;
    logic [15:0]        inv_s4_reg;
    // stage 5
    logic signed [15:0] id_s5_reg, iq_s5_reg;
    logic signed [50:0] ap_s5_reg, bp_s5_reg;
    // stage 6
    logic signed [15:0] id_s6_reg, iq_s6_reg;
    logic signed [MOD_W-1:0] a_s6_reg, bs_s6_reg, b2_s6_reg;
    logic               alpha_neg_s6_reg, beta_neg_s6_reg;
    // stage 7
    logic signed [15:0] id_s7_reg, iq_s7_reg;
    logic signed [MOD_W-1:0] da_s7_reg, db_s7_reg, dc_s7_reg;
    logic [2:0]         sec_s7_reg;
    // stage 8
    logic signed [15:0] id_out_reg, iq_out_reg;
    logic [15:0]        da_out_reg, db_out_reg, dc_out_reg;
    logic [2:0]         sec_out_reg;
    logic               ok_out_reg;

    // pipeline advance
    assign en       = !(valid_reg[STAGES-1] && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        valid_next = {valid_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    // trig unit, two stages
    fcps_sincos u_sincos (
        .clk    (clk),
        .en     (en),
        .angle  (rotor_angle),
        .sine   (sin_s2),
        .cosine (cos_s2)
    );

    // stage 1: capture, clarke product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ia_s1_reg    <= phase_a_current;
            vd_s1_reg    <= direct_voltage;
            vq_s1_reg    <= quadrature_voltage;
            inv_s1_reg   <= bus_inverse;
            bprod_s1_reg <= 35'(35'(phase_b_current) - 35'(phase_c_current)) * 35'(INV_SQRT3_Q16);
        end
    end

    // stage 2: i_beta rounding
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ia_s2_reg    <= ia_s1_reg;
            vd_s2_reg    <= vd_s1_reg;
            vq_s2_reg    <= vq_s1_reg;
            inv_s2_reg   <= inv_s1_reg;
            ibeta_s2_reg <= 18'((bprod_s1_reg + 35'sd32768) >>> 16);
        end
    end

    // stage 3: rotation products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ia_c_reg <= 32'(ia_s2_reg) * 32'(cos_s2);
            p_ia_s_reg <= 32'(ia_s2_reg) * 32'(sin_s2);
            p_ib_s_reg <= 34'(ibeta_s2_reg) * 34'(sin_s2);
            p_ib_c_reg <= 34'(ibeta_s2_reg) * 34'(cos_s2);
            p_vd_c_reg <= 32'(vd_s2_reg) * 32'(cos_s2);
            p_vq_s_reg <= 32'(vq_s2_reg) * 32'(sin_s2);
            p_vd_s_reg <= 32'(vd_s2_reg) * 32'(sin_s2);
            p_vq_c_reg <= 32'(vq_s2_reg) * 32'(cos_s2);
            inv_s3_reg <= inv_s2_reg;
        end
    end

    // stage 4: park sums with rounding and saturation, inverse park sums
    logic signed [34:0] id_sum, iq_sum;
    logic signed [34:0] id_rnd, iq_rnd;

    always_comb
    begin
        id_sum = 35'(p_ia_c_reg) + 35'(p_ib_s_reg);
        iq_sum = 35'(p_ib_c_reg) - 35'(p_ia_s_reg);
        id_rnd = (id_sum + 35'sd16384) >>> 15;
        iq_rnd = (iq_sum + 35'sd16384) >>> 15;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            id_s4_reg <= (id_rnd > 35'sd32767) ? 16'sh7FFF
                       : (id_rnd < -35'sd32768) ? 16'sh8000 : id_rnd[15:0];
            iq_s4_reg <= (iq_rnd > 35'sd32767) ? 16'sh7FFF
                       : (iq_rnd < -35'sd32768) ? 16'sh8000 : iq_rnd[15:0];
            va_s4_reg  <= 33'(p_vd_c_reg) - 33'(p_vq_s_reg);
            vb_s4_reg  <= 33'(p_vd_s_reg) + 33'(p_vq_c_reg);
            inv_s4_reg <= inv_s3_reg;
        end
    end

    // stage 5: bus normalization products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            id_s5_reg <= id_s4_reg;
            iq_s5_reg <= iq_s4_reg;
            ap_s5_reg <= 51'(va_s4_reg) * 51'($signed({1'b0, inv_s4_reg}));
            bp_s5_reg <= 51'(vb_s4_reg) * 51'($signed({1'b0, inv_s4_reg}));
        end
    end

    // stage 6: alpha, beta rounding and on-time products
    logic signed [50:0] alpha_w, beta_w;
    logic signed [24:0] alpha_v, beta_v;

    always_comb
    begin
        alpha_w = (ap_s5_reg + 51'sd33554432) >>> 26;
        beta_w  = (bp_s5_reg + 51'sd33554432) >>> 26;
        alpha_v = alpha_w[24:0];
        beta_v  = beta_w[24:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            id_s6_reg        <= id_s5_reg;
            iq_s6_reg        <= iq_s5_reg;
            a_s6_reg         <= MOD_W'(alpha_v) <<< 16;
            bs_s6_reg        <= MOD_W'(beta_v) * MOD_W'(INV_SQRT3_Q16);
            b2_s6_reg        <= MOD_W'(beta_v) * MOD_W'(TWO_INV_SQRT3_Q16);
            alpha_neg_s6_reg <= alpha_v[24];
            beta_neg_s6_reg  <= beta_v[24];
        end
    end

    // stage 7: sextant choice and doubled duties
    logic [2:0]              sec_c;
    logic signed [MOD_W-1:0] ta, tb;
    logic signed [MOD_W-1:0] da_c, db_c, dc_c;

    always_comb
    begin
        if (!beta_neg_s6_reg)
        begin
            if (!alpha_neg_s6_reg)
                sec_c = (bs_s6_reg > a_s6_reg) ? SECTOR_2 : SECTOR_1;
            else
                sec_c = (-bs_s6_reg > a_s6_reg) ? SECTOR_3 : SECTOR_2;
        end
        else
        begin
            if (!alpha_neg_s6_reg)
                sec_c = (-bs_s6_reg > a_s6_reg) ? SECTOR_5 : SECTOR_6;
            else
                sec_c = (bs_s6_reg > a_s6_reg) ? SECTOR_4 : SECTOR_5;
        end
    end

    always_comb
    begin
        ta = '0;
        tb = '0;
        da_c = '0;
        db_c = '0;
        dc_c = '0;
        unique case (sec_c)
            SECTOR_1:
            begin
                ta = a_s6_reg - bs_s6_reg;
                tb = b2_s6_reg;
                da_c = ONE_Q32 - ta - tb;
                db_c = da_c + (ta <<< 1);
                dc_c = db_c + (tb <<< 1);
            end
            SECTOR_2:
            begin
                ta = a_s6_reg + bs_s6_reg;
                tb = bs_s6_reg - a_s6_reg;
                db_c = ONE_Q32 - ta - tb;
                da_c = db_c + (tb <<< 1);
                dc_c = da_c + (ta <<< 1);
            end
            SECTOR_3:
            begin
                ta = b2_s6_reg;
                tb = -a_s6_reg - bs_s6_reg;
                db_c = ONE_Q32 - ta - tb;
                dc_c = db_c + (ta <<< 1);
                da_c = dc_c + (tb <<< 1);
            end
            SECTOR_4:
            begin
                ta = bs_s6_reg - a_s6_reg;
                tb = -b2_s6_reg;
                dc_c = ONE_Q32 - ta - tb;
                db_c = dc_c + (tb <<< 1);
                da_c = db_c + (ta <<< 1);
            end
            SECTOR_5:
            begin
                ta = -a_s6_reg - bs_s6_reg;
                tb = a_s6_reg - bs_s6_reg;
                dc_c = ONE_Q32 - ta - tb;
                da_c = dc_c + (ta <<< 1);
                db_c = da_c + (tb <<< 1);
            end
            default:
            begin
                ta = -b2_s6_reg;
                tb = a_s6_reg + bs_s6_reg;
                da_c = ONE_Q32 - ta - tb;
                dc_c = da_c + (tb <<< 1);
                db_c = dc_c + (ta <<< 1);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            id_s7_reg  <= id_s6_reg;
            iq_s7_reg  <= iq_s6_reg;
            da_s7_reg  <= da_c;
            db_s7_reg  <= db_c;
            dc_s7_reg  <= dc_c;
            sec_s7_reg <= sec_c;
        end
    end

    // stage 8: duty rounding, clamp and range flag
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            id_out_reg  <= id_s7_reg;
            iq_out_reg  <= iq_s7_reg;
            da_out_reg  <= duty_sat(da_s7_reg);
            db_out_reg  <= duty_sat(db_s7_reg);
            dc_out_reg  <= duty_sat(dc_s7_reg);
            sec_out_reg <= sec_s7_reg;
            ok_out_reg  <= !(duty_bad(da_s7_reg) || duty_bad(db_s7_reg)
                             || duty_bad(dc_s7_reg));
        end
    end

    assign out_valid          = valid_reg[STAGES-1];
    assign direct_current     = id_out_reg;
    assign quadrature_current = iq_out_reg;
    assign duty_a             = da_out_reg;
    assign duty_b             = db_out_reg;
    assign duty_c             = dc_out_reg;
    assign sector             = sec_out_reg;
    assign duties_valid       = ok_out_reg;

    // checks
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sector >= SECTOR_1 && sector <= SECTOR_6))
        else $error("sector out of range");

    a_invalid_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !duties_valid) |->
        (duty_a == 16'd0 || duty_a == 16'hFFFF || duty_b == 16'd0 || duty_b == 16'hFFFF
         || duty_c == 16'd0 || duty_c == 16'hFFFF))
        else $error("invalid duties without a clamped phase");

    a_sector1_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sector == SECTOR_1) |-> (duty_a <= duty_b && duty_b <= duty_c))
        else $error("sector one duty order broken");

endmodule

// File: rtl/core/fcps_sincos.sv
// sine and cosine of the rotor angle: registered table read, then sign stage
// depends on fcps_pkg for the table geometry and builder
module fcps_sincos (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        angle,
    output logic signed [15:0] sine,
    output logic signed [15:0] cosine
);
    import fcps_pkg::*;

    localparam sine_rom_t SINE_ROM = sine_rom_build();
    localparam logic [SINE_IDX_W-1:0] K_FULL = SINE_IDX_W'(SINE_ENTRIES - 1);

    logic [15:0]           cos_angle;
    logic [SINE_IDX_W-1:0] sin_k;
    logic [SINE_IDX_W-1:0] cos_k;
    logic [14:0]           sin_mag_reg;
    logic [14:0]           cos_mag_reg;
    logic                  sin_neg_reg;
    logic                  cos_neg_reg;
    logic signed [15:0]    sine_reg;
    logic signed [15:0]    cosine_reg;

    // quadrant mirror of the table index
    always_comb
    begin
        cos_angle = angle + 16'd16384;
        sin_k = angle[14]
            ? K_FULL - {1'b0, angle[13 -: SINE_TABLE_BITS]}
            : {1'b0, angle[13 -: SINE_TABLE_BITS]};
        cos_k = cos_angle[14]
            ? K_FULL - {1'b0, cos_angle[13 -: SINE_TABLE_BITS]}
            : {1'b0, cos_angle[13 -: SINE_TABLE_BITS]};
    end

    // registered table read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_mag_reg <= SINE_ROM[sin_k];
            cos_mag_reg <= SINE_ROM[cos_k];
            sin_neg_reg <= angle[15];
            cos_neg_reg <= cos_angle[15];
        end
    end

    // negate in the lower half turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg   <= sin_neg_reg ? -$signed({1'b0, sin_mag_reg}) : $signed({1'b0, sin_mag_reg});
            cosine_reg <= cos_neg_reg ? -$signed({1'b0, cos_mag_reg}) : $signed({1'b0, cos_mag_reg});
        end
    end

    assign sine   = sine_reg;
    assign cosine = cosine_reg;

endmodule
